@@ design/kabf_pkg.sv @@
package kabf_pkg;

	// Widths of the fixed-point formats.
	localparam int unsigned DataW = 32;   // Q16.16 angle, rate, bias; Q8.24 time and noises
	localparam int unsigned CovW  = 48;   // Q16.32 covariance and gains
	localparam int unsigned OpW   = 49;   // signed operand width of the shared units

	// Configuration register indexes.
	localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

	localparam logic [DataW-1:0] ANGLE_NOISE_RST = 32'd16777;
	localparam logic [DataW-1:0] BIAS_NOISE_RST  = 32'd50331;
	localparam logic [DataW-1:0] MEAS_NOISE_RST  = 32'd503316;

	// Saturation bounds of a 48-bit signed magnitude result.
	localparam logic [CovW-1:0] CAP_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [CovW-1:0] CAP_NEG = 48'h8000_0000_0000;

	// Right shift applied after a product.
	typedef enum logic [1:0] {
		SH16,
		SH24,
		SH32
	} shift_t;

	typedef struct packed {
		logic                   start;
		logic signed [OpW-1:0]  a;
		logic signed [OpW-1:0]  b;
		shift_t                 sh;
	} mul_req_t;

	typedef struct packed {
		logic                   start;
		logic signed [CovW-1:0] n;
		logic signed [OpW-1:0]  d;
	} div_req_t;

endpackage

@@ design/kalman_angle_bias_filter_core.sv @@
// Two-state angle and gyro-bias Kalman filter.
//
// Samples arrive on the s_ channel: one transfer carries the measured angle,
// the measured gyro rate and the time step since the previous sample. Each
// accepted sample produces exactly one result transfer on the m_ channel with
// the corrected angle and the current bias estimate.
//
// The block works on one sample at a time. A single 48x48 multiplier built
// from four 24x24 partial products and a restoring divider that retires one
// quotient bit per cycle (a gain ends early when it saturates or the
// denominator is zero) are sequenced over ten products and two divisions.
// m_tvalid rises once the last covariance entry is corrected and the result
// is committed, and the next sample can be taken from then on. The divider
// dominates the update time. s_tready is high only while idle.
//
// Reset clears the angle, the bias and the whole covariance to zero and loads
// the default noise registers. The cfg_ channel writes a noise register;
// writes with an index beyond the list are dropped. When the
// receiver stalls, the result holds on m_tdata and the block waits before
// committing the next result, so nothing is lost or repeated.
module kalman_angle_bias_filter_core import kabf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // measured_angle, measured_rate, time_step
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // filtered_angle, rate_bias
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_OUT
	} state_t;

	// Steps of one filter update, in order.
	typedef enum logic [3:0] {
		ST_ANG,   // angle prediction from the corrected rate
		ST_T,     // dt * p11, cross terms and bracketed angle-variance term
		ST_P0,    // angle variance prediction
		ST_P3,    // bias variance prediction, innovation and its covariance
		ST_K0,    // angle gain
		ST_K1,    // bias gain
		ST_CA,    // angle correction
		ST_CB,    // bias correction
		ST_C2,    // covariance correction, entry 10
		ST_C3,    // entry 11
		ST_C1,    // entry 01
		ST_C0     // entry 00
	} step_t;

	state_t                    state_q;
	step_t                     step_q;
	logic [DataW-1:0]          qa_q, qb_q, rm_q;
	logic signed [DataW-1:0]   ang_q, bias_q, z_q, w_q;
	logic [DataW-1:0]          dt_q;
	logic signed [CovW-1:0]    p0_q, p1_q, p2_q, p3_q, inner_q, k0_q, k1_q;
	logic signed [DataW:0]     y_q;
	logic signed [OpW-1:0]     s_q;
	logic [63:0]               out_q;

	mul_req_t                  mreq;
	div_req_t                  dreq;
	logic                      mul_done, div_done, unit_done, is_div;
	logic signed [CovW-1:0]    mres, dres;
	logic signed [OpW-1:0]     dt_op, qb_op, rate_op;
	logic signed [51:0]        inner_sum;

	function automatic logic signed [CovW-1:0] sat48(input logic signed [51:0] v);
		if (v > 52'sh0_7FFF_FFFF_FFFF) return CAP_POS;
		if (v < -52'sh0_8000_0000_0000) return CAP_NEG;
		return v[CovW-1:0];
	endfunction

	function automatic logic signed [DataW-1:0] sat32(input logic signed [51:0] v);
		if (v > 52'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -52'sh8000_0000) return 32'h8000_0000;
		return v[DataW-1:0];
	endfunction

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	assign dt_op   = signed'({17'd0, dt_q});
	assign qb_op   = signed'({17'd0, qb_q});
	assign rate_op = OpW'(w_q) - OpW'(bias_q);
	assign is_div  = (step_q == ST_K0) || (step_q == ST_K1);
	assign unit_done = is_div ? div_done : mul_done;
	assign inner_sum = 52'(mres) - 52'(p1_q) - 52'(p2_q) + signed'({12'd0, qa_q, 8'd0});

	// Operand selection for the shared units.
	always_comb begin
		mreq.start = (state_q == S_ISSUE) && !is_div;
		mreq.a     = dt_op;
		mreq.b     = rate_op;
		mreq.sh    = SH24;
		case (step_q)
			ST_T:  mreq.b = OpW'(p3_q);
			ST_P0: mreq.b = OpW'(inner_q);
			ST_P3: begin
				mreq.a  = qb_op;
				mreq.b  = dt_op;
				mreq.sh = SH16;
			end
			ST_CA: begin
				mreq.a  = OpW'(k0_q);
				mreq.b  = OpW'(y_q);
				mreq.sh = SH32;
			end
			ST_CB: begin
				mreq.a  = OpW'(k1_q);
				mreq.b  = OpW'(y_q);
				mreq.sh = SH32;
			end
			ST_C2: begin
				mreq.a  = OpW'(k1_q);
				mreq.b  = OpW'(p0_q);
				mreq.sh = SH32;
			end
			ST_C3: begin
				mreq.a  = OpW'(k1_q);
				mreq.b  = OpW'(p1_q);
				mreq.sh = SH32;
			end
			ST_C1: begin
				mreq.a  = OpW'(k0_q);
				mreq.b  = OpW'(p1_q);
				mreq.sh = SH32;
			end
			ST_C0: begin
				mreq.a  = OpW'(k0_q);
				mreq.b  = OpW'(p0_q);
				mreq.sh = SH32;
			end
			default: ;
		endcase
		dreq.start = (state_q == S_ISSUE) && is_div;
		dreq.n     = (step_q == ST_K1) ? p2_q : p0_q;
		dreq.d     = s_q;
	end

	kabf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.result (mres)
	);

	kabf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.result (dres)
	);

	// Sequencer, filter state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= ST_ANG;
			m_tvalid <= 1'b0;
			qa_q     <= ANGLE_NOISE_RST;
			qb_q     <= BIAS_NOISE_RST;
			rm_q     <= MEAS_NOISE_RST;
			ang_q    <= '0;
			bias_q   <= '0;
			p0_q     <= '0;
			p1_q     <= '0;
			p2_q     <= '0;
			p3_q     <= '0;
		end else begin
			// In S_OUT the handshake is handled together with the new result.
			if (m_tvalid && m_tready && state_q != S_OUT) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_addr)
					REG_ANGLE_NOISE: qa_q <= cfg_data;
					REG_BIAS_NOISE:  qb_q <= cfg_data;
					REG_MEAS_NOISE:  rm_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_ISSUE;
						step_q  <= ST_ANG;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (unit_done) begin
						state_q <= S_ISSUE;
						step_q  <= step_t'(step_q + 4'd1);
						case (step_q)
							ST_ANG: ang_q <= sat32(52'(ang_q) + 52'(mres));
							ST_T: begin
								p1_q <= sat48(52'(p1_q) - 52'(mres));
								p2_q <= sat48(52'(p2_q) - 52'(mres));
							end
							ST_P0: p0_q <= sat48(52'(p0_q) + 52'(mres));
							ST_P3: p3_q <= sat48(52'(p3_q) + 52'(mres));
							ST_CA: ang_q <= sat32(52'(ang_q) + 52'(mres));
							ST_CB: bias_q <= sat32(52'(bias_q) + 52'(mres));
							ST_C2: p2_q <= sat48(52'(p2_q) - 52'(mres));
							ST_C3: p3_q <= sat48(52'(p3_q) - 52'(mres));
							ST_C1: p1_q <= sat48(52'(p1_q) - 52'(mres));
							ST_C0: begin
								p0_q    <= sat48(52'(p0_q) - 52'(mres));
								state_q <= S_OUT;
							end
							default: ;
						endcase
					end
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sample capture and intermediate values; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			z_q  <= s_tdata[31:0];
			w_q  <= s_tdata[63:32];
			dt_q <= s_tdata[95:64];
		end
		if (state_q == S_WAIT && unit_done) begin
			case (step_q)
				ST_T:  inner_q <= sat48(inner_sum);
				ST_P3: begin
					y_q <= (DataW+1)'(z_q) - (DataW+1)'(ang_q);
					s_q <= OpW'(p0_q) + signed'({9'd0, rm_q, 8'd0});
				end
				ST_K0: k0_q <= dres;
				ST_K1: k1_q <= dres;
				default: ;
			endcase
		end
		if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
			out_q <= {bias_q, ang_q};
		end
	end

	assign m_tdata = out_q;

	// A new sample always starts the update at its first step.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_ISSUE && step_q == ST_ANG))
		else $error("update did not start at the first step");

	// Shared units only finish while the sequencer waits for them.
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_WAIT && !is_div))
		else $error("multiplier finished outside a product step");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_WAIT && is_div))
		else $error("divider finished outside a gain step");

	// A finished update waits while the previous result is still held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && m_tvalid && !m_tready) |=> (state_q == S_OUT))
		else $error("result committed over a stalled transfer");

endmodule

@@ design/kabf_mul.sv @@
module kabf_mul import kabf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mul_req_t               req,
	output logic                   done,
	output logic signed [CovW-1:0] result
);

	logic [CovW-1:0]   ua_q, ub_q;
	logic              neg_q;
	shift_t            sh_q;
	logic [2:0]        cnt_q;
	logic              busy_q;
	logic              pv_s1;
	logic [1:0]        pos_s1;
	logic [47:0]       pp_s1;
	logic [95:0]       acc_q;

	logic [23:0]       part_a, part_b;
	logic [5:0]        shamt;
	logic [96:0]       half, rnd, shifted;
	logic              over;
	logic [CovW-1:0]   cap, mag_r;

	function automatic logic [CovW-1:0] mag49(input logic signed [OpW-1:0] v);
		logic signed [OpW-1:0] n;
		n = -v;
		return v[OpW-1] ? n[CovW-1:0] : v[CovW-1:0];
	endfunction

	assign part_a = cnt_q[0] ? ua_q[47:24] : ua_q[23:0];
	assign part_b = cnt_q[1] ? ub_q[47:24] : ub_q[23:0];

	always_comb begin
		case (sh_q)
			SH16:    shamt = 6'd16;
			SH24:    shamt = 6'd24;
			default: shamt = 6'd32;
		endcase
		half    = 97'd1 << (shamt - 6'd1);
		rnd     = {1'b0, acc_q} + half;
		shifted = rnd >> shamt;
		cap     = neg_q ? CAP_NEG : CAP_POS;
		over    = (shifted[96:48] != '0) || (shifted[47:0] > cap);
		mag_r   = over ? cap : shifted[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			pv_s1  <= 1'b0;
			done   <= 1'b0;
		end else begin
			done  <= 1'b0;
			pv_s1 <= busy_q && !cnt_q[2];
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q  <= mag49(req.a);
			ub_q  <= mag49(req.b);
			neg_q <= req.a[OpW-1] ^ req.b[OpW-1];
			sh_q  <= req.sh;
			acc_q <= '0;
		end else begin
			pp_s1  <= part_a * part_b;
			pos_s1 <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
			if (pv_s1) begin
				case (pos_s1)
					2'd0:    acc_q <= acc_q + {48'd0, pp_s1};
					2'd1:    acc_q <= acc_q + {24'd0, pp_s1, 24'd0};
					default: acc_q <= acc_q + {pp_s1, 48'd0};
				endcase
			end
			if (busy_q && cnt_q == 3'd5) begin
				result <= neg_q ? -mag_r : mag_r;
			end
		end
	end

endmodule

@@ design/kabf_div.sv @@
module kabf_div import kabf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  div_req_t               req,
	output logic                   done,
	output logic signed [CovW-1:0] result
);

	typedef enum logic [1:0] {
		D_IDLE,
		D_CHECK,
		D_ITER,
		D_FIN
	} dstate_t;

	dstate_t          state_q;
	logic [5:0]       cnt_q;
	logic [CovW-1:0]  un_q, q_q;
	logic [OpW-1:0]   ud_q, r_q;
	logic             neg_q;

	logic [15:0]      un_lo;
	logic             bit_in;
	logic [OpW:0]     rs;
	logic             ge;
	logic [CovW-1:0]  cap, qm;
	logic signed [CovW:0]  nn;
	logic signed [OpW-1:0] nd;

	assign un_lo  = un_q[15:0];
	assign bit_in = cnt_q[5] ? un_lo[cnt_q[3:0]] : 1'b0;
	assign rs     = {r_q, bit_in};
	assign ge     = rs >= {1'b0, ud_q};
	assign cap    = neg_q ? CAP_NEG : CAP_POS;
	assign qm     = (q_q > cap) ? cap : q_q;
	assign nn     = -(CovW+1)'(req.n);
	assign nd     = -req.d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					if (ud_q == '0 || {17'd0, un_q} >= {ud_q, 16'd0}) begin
						state_q <= D_IDLE;
						done    <= 1'b1;
					end else begin
						state_q <= D_ITER;
					end
				end
				D_ITER: begin
					if (cnt_q == '0) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					state_q <= D_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && req.start) begin
			un_q  <= req.n[CovW-1] ? nn[CovW-1:0] : req.n;
			ud_q  <= req.d[OpW-1] ? nd : req.d;
			neg_q <= req.n[CovW-1] ^ req.d[OpW-1];
		end
		if (state_q == D_CHECK) begin
			r_q   <= {17'd0, un_q[47:16]};
			q_q   <= '0;
			cnt_q <= 6'd47;
			if (ud_q == '0) begin
				result <= '0;
			end else begin
				result <= neg_q ? -cap : cap;
			end
		end
		if (state_q == D_ITER) begin
			cnt_q <= cnt_q - 6'd1;
			q_q   <= {q_q[CovW-2:0], ge};
			r_q   <= ge ? OpW'(rs - {1'b0, ud_q}) : rs[OpW-1:0];
		end
		if (state_q == D_FIN) begin
			result <= neg_q ? -qm : qm;
		end
	end

endmodule
